// ----- hw/rtl/suse_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set engine package
// Shared sizes, action and status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package suse_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 3;
    localparam int OCNT_W   = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_DUMP   = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/suse_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module suse_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_unique_set_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set engine
// Ordered set of distinct signed 32-bit values with clear, insert, delete,
// search and dump actions.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries an action and a key. s_ready is high
// only while the sequencer is idle; one action is worked at a time.
// Result channel m_*: one beat per action, or one beat per stored value for
// a dump of a non-empty set (empty set gives a single beat). m_last_of_run
// marks the final beat of an action; every beat carries the count after it.
// Operation: values sit in one RAM with registered read. Insert, delete and
// search scan from the low end, reading and then comparing each entry
// passed over. Insert then shifts the tail up and delete shifts it down,
// with a read and a write per moved entry. Clear and unused codes go
// straight to the result beat. A dump reads each value, then emits it.
// The result sits in an output register, so the next action is accepted
// while it waits; a stalled receiver holds the sequencer at its next beat.
// Reset (aresetn low, synchronous) empties the set and drops any pending
// beat; the RAM needs no clearing since only stored entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_engine_unit
    import suse_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [ACT_W-1:0]        s_action,
    input  wire logic signed [KEY_W-1:0] s_key_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [STAT_W-1:0]            m_status,
    output logic signed [KEY_W-1:0]      m_element_value,
    output logic [OCNT_W-1:0]            m_element_count,
    output logic                         m_last_of_run
);

    state_t                   state_reg, state_next;
    action_t                  action_reg, action_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic                     match_reg, match_next;
    status_t                  status_reg, status_next;

    logic                     m_valid_reg, m_valid_next;
    status_t                  m_status_reg, m_status_next;
    logic signed [KEY_W-1:0]  m_value_reg, m_value_next;
    logic [CNT_W-1:0]         m_count_reg, m_count_next;
    logic                     m_last_reg, m_last_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [KEY_W-1:0]         wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [KEY_W-1:0]         rd_data;
    logic signed [KEY_W-1:0]  rd_val;

    logic                     out_free;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         idx_dec;

    suse_ram #(
        .DATA_W (KEY_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_val   = $signed(rd_data);
    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        match_next    = match_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        s_ready       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[ADDR_W-1:0];
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next = action_t'(s_action);
                    key_next    = s_key_value;
                    idx_next    = '0;
                    status_next = ST_DONE;
                    unique case (s_action)
                        ACT_CLEAR: begin
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        ACT_INSERT, ACT_DELETE, ACT_SEARCH: begin
                            state_next = S_SCAN_RD;
                        end
                        ACT_DUMP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    match_next = 1'b0;
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP: begin
                // advance past smaller values, stop at first not-less entry
                if (rd_val < key_reg) begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end else begin
                    pos_next   = idx_reg;
                    match_next = (rd_val == key_reg);
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                state_next = S_EMIT;
                unique case (action_reg)
                    ACT_SEARCH: begin
                        status_next = match_reg ? ST_FOUND : ST_NOT_FOUND;
                    end
                    ACT_INSERT: begin
                        if (match_reg) begin
                            status_next = ST_DUPLICATE;
                        end else if (count_reg >= CNT_W'(CAPACITY)) begin
                            status_next = ST_FULL;
                        end else begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    ACT_DELETE: begin
                        if (match_reg) begin
                            idx_next   = pos_reg;
                            state_next = S_DEL_RD;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        status_next = ST_DONE;
                    end
                endcase
            end

            S_INS_RD: begin
                if (idx_reg == pos_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = key_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[ADDR_W-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR: begin
                // move entry one slot up
                wr_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end

            S_DEL_RD: begin
                if (idx_inc >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[ADDR_W-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                // move entry one slot down
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end

            S_DUMP_RD: begin
                rd_en      = 1'b1;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT: begin
                // hold read data until the output register frees up
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_DONE;
                    m_value_next  = rd_val;
                    m_count_next  = count_reg;
                    m_last_next   = (idx_inc == count_reg);
                    if (idx_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = '0;
                    m_count_next  = count_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_element_value = m_value_reg;
    assign m_element_count = OCNT_W'(m_count_reg);
    assign m_last_of_run   = m_last_reg;

endmodule

`default_nettype wire
